// ===== rtl/core/isb_pkg.sv =====
// Shared types and constants for the indexed sprite blitter.
package isb_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int REG_W           = 13;
	localparam int ADDR_W          = 24;
	localparam int PIXEL_W         = 32;
	localparam int RGB_W           = 24;

	localparam logic [PIXEL_W-1:0] ALPHA_OPAQUE      = 32'hff00_0000;
	localparam logic [RGB_W-1:0]   HALF_MASK         = 24'h7f_7f7f;
	localparam logic [7:0]         SHADOW_INDEX      = 8'd4;
	localparam logic [7:0]         TRANSPARENT_INDEX = 8'd0;

	localparam logic FUNC_PALETTE = 1'b0;
	localparam logic FUNC_PIXEL   = 1'b1;

	typedef enum logic [3:0] {
		REG_CANVAS_WIDTH  = 4'd0,
		REG_CANVAS_HEIGHT = 4'd1,
		REG_CANVAS_PITCH  = 4'd2,
		REG_OFFSET_X      = 4'd3,
		REG_OFFSET_Y      = 4'd4,
		REG_SOURCE_WIDTH  = 4'd5,
		REG_SOURCE_HEIGHT = 4'd6,
		REG_KEY_ENABLE    = 4'd7
	} isb_reg_t;

	typedef struct packed {
		logic [REG_W-1:0]        canvas_width;
		logic [REG_W-1:0]        canvas_height;
		logic [REG_W-1:0]        canvas_pitch;
		logic signed [REG_W-1:0] offset_x;
		logic signed [REG_W-1:0] offset_y;
		logic [REG_W-1:0]        source_width;
		logic [REG_W-1:0]        source_height;
		logic                    key_enable;
	} isb_cfg_t;

	// Stage 1 contents: clip and key decisions already made.
	typedef struct packed {
		logic               write;
		logic               shadow;
		logic               last;
		logic [REG_W-1:0]   col;
		logic [REG_W-1:0]   row;
		logic [PIXEL_W-1:0] existing;
		logic [RGB_W-1:0]   rgb;
	} isb_stage_t;

	typedef struct packed {
		logic               write_enable;
		logic [ADDR_W-1:0]  write_address;
		logic [PIXEL_W-1:0] write_pixel;
		logic               last;
	} isb_result_t;

endpackage

// ===== rtl/core/indexed_sprite_blitter.sv =====
// Top level of the indexed sprite blitter: handshake, pipeline control, checks.
//
// Usage:
//   s_axis carries input items. tuser is func (0 palette write, 1 source pixel).
//   A palette write loads one RGB entry; source pixels come in raster order and
//   each produces exactly one result on m_axis, in order.
//   m_axis tuser is write_enable, tlast marks the last pixel of the rectangle.
//   cfg is a register write port (index, 13-bit data), always ready; write it
//   only while no item is in flight.
// Timing:
//   Two register stages: stage 1 does clip/key decode and the palette read,
//   stage 2 is the output register (row * pitch + column multiply there).
//   A result is valid on m_axis once it has passed the stage 1 and stage 2 registers;
//   one item per cycle sustained while m_axis_tready stays high.
// Stalls:
//   When m_axis_tready is low the output holds; s_axis_tready drops only once both
//   stages are full, so one more item is taken while a result waits.
// Reset:
//   arst_n clears the counters, valids and configuration registers to their defaults.
//   The palette is not cleared; entries must be written before being used.
module indexed_sprite_blitter
	import isb_pkg::*;
#(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	// input stream
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// [7:0] palette_slot, [15:8] red, [23:16] green, [31:24] blue,
	// [39:32] color_index, [71:40] existing_pixel
	input  logic [71:0]      s_axis_tdata,
	input  logic             s_axis_tuser,   // func
	// result stream
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [23:0] write_address, [55:24] write_pixel
	output logic [55:0]      m_axis_tdata,
	output logic             m_axis_tuser,   // write_enable
	output logic             m_axis_tlast,   // last
	// configuration writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [3:0]       cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	isb_cfg_t    cfg;
	isb_stage_t  stage_s1;
	isb_result_t result_s2;

	logic valid_s1, valid_s2;
	logic adv_s2, load_s1, load_s2;

	// Stage 2 moves when the output register is empty or being drained;
	// stage 1 moves when it is empty or its content goes on to stage 2.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;
	assign load_s2       = valid_s1 && adv_s2;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (adv_s2)        valid_s2 <= valid_s1;
		end
	end

	isb_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	isb_front #(
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.load           (load_s1),
		.func           (s_axis_tuser),
		.palette_slot   (s_axis_tdata[7:0]),
		.red            (s_axis_tdata[15:8]),
		.green          (s_axis_tdata[23:16]),
		.blue           (s_axis_tdata[31:24]),
		.color_index    (s_axis_tdata[39:32]),
		.existing_pixel (s_axis_tdata[71:40]),
		.stage_s1       (stage_s1)
	);

	isb_back u_back (
		.clk          (clk),
		.load         (load_s2),
		.canvas_pitch (cfg.canvas_pitch),
		.stage_s1     (stage_s1),
		.result_s2    (result_s2)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {result_s2.write_pixel, result_s2.write_address};
	assign m_axis_tuser  = result_s2.write_enable;
	assign m_axis_tlast  = result_s2.last;

	// input side only backs up when the output is full and stalled
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");

	// no write means address and pixel are zero
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("nonzero payload on a result without write");

	// every written pixel is opaque
	a_alpha_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[55:48] == 8'hff))
		else $error("written pixel without opaque alpha");

endmodule

// ===== rtl/core/isb_cfg.sv =====
// Configuration register file for the blitter.
module isb_cfg
	import isb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [3:0]       wr_index,
	input  logic [REG_W-1:0] wr_data,
	output isb_cfg_t         cfg
);

	isb_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.canvas_width  <= REG_W'(1);
			cfg_q.canvas_height <= REG_W'(1);
			cfg_q.canvas_pitch  <= REG_W'(1);
			cfg_q.offset_x      <= '0;
			cfg_q.offset_y      <= '0;
			cfg_q.source_width  <= REG_W'(1);
			cfg_q.source_height <= REG_W'(1);
			cfg_q.key_enable    <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CANVAS_WIDTH:  cfg_q.canvas_width  <= wr_data;
				REG_CANVAS_HEIGHT: cfg_q.canvas_height <= wr_data;
				REG_CANVAS_PITCH:  cfg_q.canvas_pitch  <= wr_data;
				REG_OFFSET_X:      cfg_q.offset_x      <= signed'(wr_data);
				REG_OFFSET_Y:      cfg_q.offset_y      <= signed'(wr_data);
				REG_SOURCE_WIDTH:  cfg_q.source_width  <= wr_data;
				REG_SOURCE_HEIGHT: cfg_q.source_height <= wr_data;
				REG_KEY_ENABLE:    cfg_q.key_enable    <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/isb_front.sv =====
// Raster counters, clipping, key decode and palette memory (stage 1).
module isb_front
	import isb_pkg::*;
#(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  isb_cfg_t           cfg,
	input  logic               load,
	input  logic               func,
	input  logic [7:0]         palette_slot,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic [7:0]         color_index,
	input  logic [PIXEL_W-1:0] existing_pixel,
	output isb_stage_t         stage_s1
);

	localparam int CW = $clog2(MAX_DIMENSION);
	localparam int DW = (CW + 1 > REG_W) ? CW + 1 : REG_W;
	localparam int TW = DW + 1;
	localparam logic [DW-1:0] MAX_DIM = DW'(MAX_DIMENSION);

	logic [CW-1:0]   col_q, row_q;
	logic [RGB_W-1:0] palette_mem [PALETTE_ENTRIES];

	logic [DW-1:0]        sw_raw, sh_raw, sw_eff, sh_eff;
	logic [DW-1:0]        col_inc, row_inc;
	logic                 col_wrap, row_wrap;
	logic signed [TW-1:0] tx, ty;
	logic                 on_canvas, transparent, shadow;

	always_comb begin
		sw_raw = DW'(cfg.source_width);
		sh_raw = DW'(cfg.source_height);
		sw_eff = (sw_raw == '0) ? DW'(1) : ((sw_raw > MAX_DIM) ? MAX_DIM : sw_raw);
		sh_eff = (sh_raw == '0) ? DW'(1) : ((sh_raw > MAX_DIM) ? MAX_DIM : sh_raw);
		col_inc = DW'(col_q) + DW'(1);
		row_inc = DW'(row_q) + DW'(1);
		col_wrap = (col_inc >= sw_eff);
		row_wrap = (row_inc >= sh_eff);
	end

	always_comb begin
		tx = TW'(cfg.offset_x) + signed'({{(TW-CW){1'b0}}, col_q});
		ty = TW'(cfg.offset_y) + signed'({{(TW-CW){1'b0}}, row_q});
		on_canvas = !tx[TW-1] && !ty[TW-1] &&
		            (tx < signed'({{(TW-REG_W){1'b0}}, cfg.canvas_width})) &&
		            (ty < signed'({{(TW-REG_W){1'b0}}, cfg.canvas_height}));
		transparent = cfg.key_enable && (color_index == TRANSPARENT_INDEX);
		shadow      = cfg.key_enable && (color_index == SHADOW_INDEX);
	end

	// counters move only on source pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (load && func == FUNC_PIXEL) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[CW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && func == FUNC_PALETTE) begin
			palette_mem[palette_slot] <= {red, green, blue};
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stage_s1.write    <= (func == FUNC_PIXEL) && on_canvas && !transparent;
			stage_s1.shadow   <= shadow;
			stage_s1.last     <= (func == FUNC_PIXEL) && col_wrap && row_wrap;
			stage_s1.col      <= tx[REG_W-1:0];
			stage_s1.row      <= ty[REG_W-1:0];
			stage_s1.existing <= existing_pixel;
			stage_s1.rgb      <= palette_mem[color_index];
		end
	end

endmodule

// ===== rtl/core/isb_back.sv =====
// Address multiply and pixel select into the output register (stage 2).
module isb_back
	import isb_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic [REG_W-1:0] canvas_pitch,
	input  isb_stage_t       stage_s1,
	output isb_result_t      result_s2
);

	logic [2*REG_W-1:0] row_offset;
	logic [2*REG_W-1:0] addr_full;
	logic [RGB_W-1:0]   color;

	always_comb begin
		row_offset = (2*REG_W)'(stage_s1.row) * (2*REG_W)'(canvas_pitch);
		addr_full  = row_offset + (2*REG_W)'(stage_s1.col);
		color      = stage_s1.shadow ? (stage_s1.existing[RGB_W:1] & HALF_MASK) : stage_s1.rgb;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_s2.write_enable  <= stage_s1.write;
			result_s2.write_address <= stage_s1.write ? addr_full[ADDR_W-1:0] : '0;
			result_s2.write_pixel   <= stage_s1.write ? (ALPHA_OPAQUE | PIXEL_W'(color)) : '0;
			result_s2.last          <= stage_s1.last;
		end
	end

endmodule
